>>> rtl/assert_macros.svh
// assertion helpers used by the checker file spi_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define SPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spi check failed");

// next-cycle implication, off while reset is asserted
`define SPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spi check failed");

// next-cycle implication, also checked through reset
`define SPI_ASSERT_NXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("spi check failed");

`endif

>>> rtl/spi_pkg.sv
`default_nettype none
package spi_pkg;

  localparam int CW   = 32;
  localparam int PW   = 2 * CW;
  localparam int NREG = 6;
  localparam int RIW  = $clog2(NREG);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   wide_t;
  typedef logic [CW-1:0]        mag_t;
  typedef logic [CW-2:0]        span_t;
  typedef logic [PW-1:0]        prod_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [RIW-1:0] {
    REG_ORIGIN_X = RIW'(0),
    REG_ORIGIN_Y = RIW'(1),
    REG_ORIGIN_Z = RIW'(2),
    REG_SPAN_X   = RIW'(3),
    REG_SPAN_Y   = RIW'(4),
    REG_SPAN_Z   = RIW'(5)
  } reg_idx_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    span_t  span_x;
    span_t  span_y;
    span_t  span_z;
  } plate_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
  } seg_t;

  typedef struct packed {
    logic   hit;
    coord_t hit_x;
    coord_t hit_y;
    coord_t hit_z;
    logic   config_error;
  } res_t;

  // per-item control that rides alongside the division
  typedef struct packed {
    logic   cfg_err;
    logic   miss;
    axis_t  n;
    coord_t start_a;
    coord_t start_b;
    logic   neg_a;
    logic   neg_b;
  } side_t;

  typedef struct packed {
    side_t side;
    mag_t  den;
    prod_t w_a;
    prod_t w_b;
  } div_t;

  // the two in-plane axes, in ascending order
  function automatic axis_t lane_a(axis_t n);
    return (n == AXIS_X) ? AXIS_Y : AXIS_X;
  endfunction

  function automatic axis_t lane_b(axis_t n);
    return (n == AXIS_Z) ? AXIS_Y : AXIS_Z;
  endfunction

  function automatic coord_t pick(axis_t a, coord_t x, coord_t y, coord_t z);
    coord_t r;
    case (a)
      AXIS_X:  r = x;
      AXIS_Y:  r = y;
      AXIS_Z:  r = z;
      default: r = z;
    endcase
    return r;
  endfunction

  function automatic span_t pick_span(axis_t a, span_t x, span_t y, span_t z);
    span_t r;
    case (a)
      AXIS_X:  r = x;
      AXIS_Y:  r = y;
      AXIS_Z:  r = z;
      default: r = z;
    endcase
    return r;
  endfunction

  function automatic wide_t ext(coord_t c);
    return {c[CW-1], c};
  endfunction

endpackage
`default_nettype wire

>>> rtl/spi_if.sv
`default_nettype none
interface spi_seg_if;
  import spi_pkg::*;
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t start_z;
  coord_t end_x;
  coord_t end_y;
  coord_t end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

interface spi_res_if;
  import spi_pkg::*;
  logic   valid;
  logic   ready;
  logic   hit;
  coord_t hit_x;
  coord_t hit_y;
  coord_t hit_z;
  logic   config_error;
  modport source (output valid, hit, hit_x, hit_y, hit_z, config_error, input ready);
  modport sink (input valid, hit, hit_x, hit_y, hit_z, config_error, output ready);
endinterface
`default_nettype wire

>>> rtl/segment_plate_intersect_core.sv
// channel   dir  handshake      payload
// in_seg    in   valid/ready    start_x..z, end_x..z (signed Q16.16)
// out_res   out  valid/ready    hit, hit_x..z (signed Q16.16), config_error
// cfg       in   cfg_we         cfg_idx selects origin_x..z, span_x..z; cfg_data
//
// one segment per cycle while the output is not stalled
// the 32-step restoring divider produces one quotient bit per stage
// rst_n is synchronous: clears all stage valid bits and the plate registers
// a stalled output holds its beat; each stage refills as soon as it drains
`default_nettype none
module segment_plate_intersect_core (
  input  logic                      clk,
  input  logic                      rst_n,
  spi_seg_if.sink                   in_seg,
  spi_res_if.source                 out_res,
  input  logic                      cfg_we,
  input  logic [spi_pkg::RIW-1:0]   cfg_idx,
  input  logic [spi_pkg::CW-1:0]    cfg_data
);
  import spi_pkg::*;

  plate_t plate_r;
  seg_t   seg;
  res_t   res;
  div_t   pd_data, dp_data;
  logic   pd_valid, pd_ready, dp_valid, dp_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plate_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_ORIGIN_X: plate_r.origin_x <= cfg_data;
        REG_ORIGIN_Y: plate_r.origin_y <= cfg_data;
        REG_ORIGIN_Z: plate_r.origin_z <= cfg_data;
        REG_SPAN_X:   plate_r.span_x   <= cfg_data[CW-2:0];
        REG_SPAN_Y:   plate_r.span_y   <= cfg_data[CW-2:0];
        REG_SPAN_Z:   plate_r.span_z   <= cfg_data[CW-2:0];
        default:      plate_r          <= plate_r;
      endcase
    end
  end

  assign seg.start_x = in_seg.start_x;
  assign seg.start_y = in_seg.start_y;
  assign seg.start_z = in_seg.start_z;
  assign seg.end_x   = in_seg.end_x;
  assign seg.end_y   = in_seg.end_y;
  assign seg.end_z   = in_seg.end_z;

  spi_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .plate     (plate_r),
    .in_valid  (in_seg.valid),
    .in_ready  (in_seg.ready),
    .in_data   (seg),
    .out_valid (pd_valid),
    .out_ready (pd_ready),
    .out_data  (pd_data)
  );

  spi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pd_valid),
    .in_ready  (pd_ready),
    .in_data   (pd_data),
    .out_valid (dp_valid),
    .out_ready (dp_ready),
    .out_data  (dp_data)
  );

  spi_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .plate     (plate_r),
    .in_valid  (dp_valid),
    .in_ready  (dp_ready),
    .in_data   (dp_data),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_data  (res)
  );

  assign out_res.hit          = res.hit;
  assign out_res.hit_x        = res.hit_x;
  assign out_res.hit_y        = res.hit_y;
  assign out_res.hit_z        = res.hit_z;
  assign out_res.config_error = res.config_error;

endmodule
`default_nettype wire

>>> rtl/spi_prep.sv
`default_nettype none
module spi_prep (
  input  logic            clk,
  input  logic            rst_n,
  input  spi_pkg::plate_t plate,
  input  logic            in_valid,
  output logic            in_ready,
  input  spi_pkg::seg_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output spi_pkg::div_t   out_data
);
  import spi_pkg::*;

  typedef struct packed {
    logic   cfg_err;
    axis_t  n;
    wide_t  den;
    wide_t  num;
    wide_t  dk_a;
    wide_t  dk_b;
    coord_t start_a;
    coord_t start_b;
  } sa_t;

  function automatic mag_t mag(wide_t v);
    wide_t a;
    a = v[CW] ? -v : v;
    return a[CW-1:0];
  endfunction

  logic va_r, vb_r;
  logic rdy_a, rdy_b;
  sa_t  sa_r, sa_nxt;
  div_t sb_r, sb_nxt;

  logic  zx, zy, zz;
  logic [1:0] cnt;
  axis_t n, ax_a, ax_b;
  mag_t  m_num, m_den, m_dka, m_dkb;

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  // stage a: normal axis and differences
  always_comb begin
    zx   = (plate.span_x == '0);
    zy   = (plate.span_y == '0);
    zz   = (plate.span_z == '0);
    cnt  = 2'(zx) + 2'(zy) + 2'(zz);
    n    = zx ? AXIS_X : (zy ? AXIS_Y : AXIS_Z);
    ax_a = lane_a(n);
    ax_b = lane_b(n);
    sa_nxt.cfg_err = (cnt != 2'd1);
    sa_nxt.n       = n;
    sa_nxt.den  = ext(pick(n, in_data.end_x, in_data.end_y, in_data.end_z))
                - ext(pick(n, in_data.start_x, in_data.start_y, in_data.start_z));
    sa_nxt.num  = ext(pick(n, plate.origin_x, plate.origin_y, plate.origin_z))
                - ext(pick(n, in_data.start_x, in_data.start_y, in_data.start_z));
    sa_nxt.start_a = pick(ax_a, in_data.start_x, in_data.start_y, in_data.start_z);
    sa_nxt.start_b = pick(ax_b, in_data.start_x, in_data.start_y, in_data.start_z);
    sa_nxt.dk_a = ext(pick(ax_a, in_data.end_x, in_data.end_y, in_data.end_z))
                - ext(sa_nxt.start_a);
    sa_nxt.dk_b = ext(pick(ax_b, in_data.end_x, in_data.end_y, in_data.end_z))
                - ext(sa_nxt.start_b);
  end

  // stage b: range check on t and the two products
  always_comb begin
    m_num = mag(sa_r.num);
    m_den = mag(sa_r.den);
    m_dka = mag(sa_r.dk_a);
    m_dkb = mag(sa_r.dk_b);
    sb_nxt.side.cfg_err = sa_r.cfg_err;
    sb_nxt.side.miss    = sa_r.cfg_err || (sa_r.den == '0)
                       || ((sa_r.num != '0) && (sa_r.num[CW] != sa_r.den[CW]))
                       || (m_num > m_den);
    sb_nxt.side.n       = sa_r.n;
    sb_nxt.side.start_a = sa_r.start_a;
    sb_nxt.side.start_b = sa_r.start_b;
    sb_nxt.side.neg_a   = sa_r.dk_a[CW];
    sb_nxt.side.neg_b   = sa_r.dk_b[CW];
    sb_nxt.den          = m_den;
    sb_nxt.w_a          = PW'(m_num) * PW'(m_dka);
    sb_nxt.w_b          = PW'(m_num) * PW'(m_dkb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) sa_r <= sa_nxt;
    if (rdy_b) sb_r <= sb_nxt;
  end

  assign out_valid = vb_r;
  assign out_data  = sb_r;

endmodule
`default_nettype wire

>>> rtl/spi_div.sv
`default_nettype none
module spi_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  spi_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output spi_pkg::div_t out_data
);
  import spi_pkg::*;

  // one restoring step: remainder in the high half, quotient shifts into the low half
  function automatic prod_t step(prod_t w, mag_t d);
    logic [CW:0] t;
    logic        ge;
    t  = w[PW-1:CW-1];
    ge = (t >= {1'b0, d});
    return {ge ? CW'(t - {1'b0, d}) : t[CW-1:0], w[CW-2:0], ge};
  endfunction

  logic v_r [CW];
  div_t d_r [CW];
  logic rdy [CW+1];
  logic vin [CW];
  div_t din [CW];

  assign rdy[CW] = out_ready;

  for (genvar i = 0; i < CW; i++) begin : g_stg
    if (i == 0) begin : g_first
      assign vin[i] = in_valid;
      assign din[i] = in_data;
    end else begin : g_rest
      assign vin[i] = v_r[i-1];
      assign din[i] = d_r[i-1];
    end

    assign rdy[i] = !v_r[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= vin[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        d_r[i].side <= din[i].side;
        d_r[i].den  <= din[i].den;
        d_r[i].w_a  <= step(din[i].w_a, din[i].den);
        d_r[i].w_b  <= step(din[i].w_b, din[i].den);
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[CW-1];
  assign out_data  = d_r[CW-1];

endmodule
`default_nettype wire

>>> rtl/spi_post.sv
`default_nettype none
module spi_post (
  input  logic            clk,
  input  logic            rst_n,
  input  spi_pkg::plate_t plate,
  input  logic            in_valid,
  output logic            in_ready,
  input  spi_pkg::div_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output spi_pkg::res_t   out_data
);
  import spi_pkg::*;

  typedef struct packed {
    side_t side;
    mag_t  q_a;
    mag_t  q_b;
  } s1_t;

  typedef struct packed {
    side_t  side;
    coord_t p_a;
    coord_t p_b;
  } s2_t;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  res_t s3_r, s3_nxt;

  logic   up_a, up_b, out_a, out_b, hit;
  axis_t  ax_a, ax_b;
  coord_t org_a, org_b;
  wide_t  top_a, top_b, sa, sb;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // round half up on the remainder
  always_comb begin
    up_a = {in_data.w_a[PW-1:CW], 1'b0} >= {1'b0, in_data.den};
    up_b = {in_data.w_b[PW-1:CW], 1'b0} >= {1'b0, in_data.den};
    s1_nxt.side = in_data.side;
    s1_nxt.q_a  = in_data.w_a[CW-1:0] + mag_t'(up_a);
    s1_nxt.q_b  = in_data.w_b[CW-1:0] + mag_t'(up_b);
  end

  always_comb begin
    sa = s1_r.side.neg_a ? ext(s1_r.side.start_a) - $signed({1'b0, s1_r.q_a})
                         : ext(s1_r.side.start_a) + $signed({1'b0, s1_r.q_a});
    sb = s1_r.side.neg_b ? ext(s1_r.side.start_b) - $signed({1'b0, s1_r.q_b})
                         : ext(s1_r.side.start_b) + $signed({1'b0, s1_r.q_b});
    s2_nxt.side = s1_r.side;
    s2_nxt.p_a  = sa[CW-1:0];
    s2_nxt.p_b  = sb[CW-1:0];
  end

  // bounds check and result assembly
  always_comb begin
    ax_a  = lane_a(s2_r.side.n);
    ax_b  = lane_b(s2_r.side.n);
    org_a = pick(ax_a, plate.origin_x, plate.origin_y, plate.origin_z);
    org_b = pick(ax_b, plate.origin_x, plate.origin_y, plate.origin_z);
    top_a = ext(org_a)
          + $signed({2'b00, pick_span(ax_a, plate.span_x, plate.span_y, plate.span_z)});
    top_b = ext(org_b)
          + $signed({2'b00, pick_span(ax_b, plate.span_x, plate.span_y, plate.span_z)});
    out_a = (s2_r.p_a < org_a) || (ext(s2_r.p_a) > top_a);
    out_b = (s2_r.p_b < org_b) || (ext(s2_r.p_b) > top_b);
    hit   = !s2_r.side.miss && !out_a && !out_b;
    s3_nxt.hit          = hit;
    s3_nxt.config_error = s2_r.side.cfg_err;
    s3_nxt.hit_x        = '0;
    s3_nxt.hit_y        = '0;
    s3_nxt.hit_z        = '0;
    if (hit) begin
      case (s2_r.side.n)
        AXIS_X: begin
          s3_nxt.hit_x = plate.origin_x;
          s3_nxt.hit_y = s2_r.p_a;
          s3_nxt.hit_z = s2_r.p_b;
        end
        AXIS_Y: begin
          s3_nxt.hit_x = s2_r.p_a;
          s3_nxt.hit_y = plate.origin_y;
          s3_nxt.hit_z = s2_r.p_b;
        end
        AXIS_Z: begin
          s3_nxt.hit_x = s2_r.p_a;
          s3_nxt.hit_y = s2_r.p_b;
          s3_nxt.hit_z = plate.origin_z;
        end
        default: begin
          s3_nxt.hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule
`default_nettype wire

>>> rtl/spi_checker.sv
`default_nettype none
`include "assert_macros.svh"
module spi_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_hit,
  input  logic [spi_pkg::CW-1:0] out_hit_x,
  input  logic [spi_pkg::CW-1:0] out_hit_y,
  input  logic [spi_pkg::CW-1:0] out_hit_z,
  input  logic                   out_config_error
);
  import spi_pkg::*;

  logic in_beat;
  logic [3*CW+1:0] out_pay;
  assign in_beat = in_valid && in_ready;
  assign out_pay = {out_hit, out_hit_x, out_hit_y, out_hit_z, out_config_error};

  // nothing leaves right after reset
  `SPI_ASSERT_NXT_ALL(a_rst_quiet, !rst_n, !out_valid)

  // a stalled result beat holds
  `SPI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pay))

  // a miss reports a zero point
  `SPI_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, (out_hit_x == '0) && (out_hit_y == '0) && (out_hit_z == '0))

  // a bad plate never hits
  `SPI_ASSERT_IMP(a_cfg_miss, out_valid && out_config_error, !out_hit)

  // an empty pipe with a free output accepts
  `SPI_ASSERT_IMP(a_ready_free, in_valid && out_ready && !out_valid && $past(!out_valid) && $past(!in_beat), in_ready)

endmodule

bind segment_plate_intersect_core spi_checker u_spi_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_seg.valid),
  .in_ready         (in_seg.ready),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_hit          (out_res.hit),
  .out_hit_x        (out_res.hit_x),
  .out_hit_y        (out_res.hit_y),
  .out_hit_z        (out_res.hit_z),
  .out_config_error (out_res.config_error)
);
`default_nettype wire
